// ===== hdl/multichannel_servo_pwm_core_defines.svh =====
// ----------------------------------------------------------------------------
// Servo PWM core assertion macros
// Shared property wrappers for the servo PWM core checks.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SERVO_PWM_CORE_DEFINES_SVH
`define MULTICHANNEL_SERVO_PWM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("servo pwm core check failed");

// Next-cycle implication, disabled during reset.
`define MSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("servo pwm core check failed");

`endif

// ===== hdl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo PWM package
// Shared constants and types of the multichannel servo PWM core.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int CHANNELS_DEF = 24;
    localparam int STEPS_DEF    = 256;

    localparam int FRAME_W    = 24;
    localparam int MIN_W      = 16;
    localparam int STEP_W     = 10;
    localparam int POS_W      = 8;
    localparam int CHAN_W     = 5;
    localparam int STEP_IDX_W = 9;   // holds a step count up to 256
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [FRAME_W-1:0] FRAME_PERIOD_RST = 24'd960000;
    localparam logic [MIN_W-1:0]   MIN_PULSE_RST    = 16'd48000;
    localparam logic [STEP_W-1:0]  STEP_TICKS_RST   = 10'd188;
    localparam logic [POS_W-1:0]   POS_RST          = 8'd128;

    // input item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PULSE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_TICKS   = 2'd2;

    // per-tick events from the frame timer to the channel bank
    typedef struct packed {
        logic                  start;
        logic                  step_done;
        logic                  all_low;
        logic [STEP_IDX_W-1:0] step_index;
    } timing_t;

endpackage

// ===== hdl/msp_frame_timer.sv =====
// ----------------------------------------------------------------------------
// Servo PWM frame timer
// Frame counter, minimum-pulse counter and step sequencer.
// ----------------------------------------------------------------------------
module msp_frame_timer #(
    parameter int STEPS = msp_pkg::STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick_en,
    input  logic [msp_pkg::FRAME_W-1:0]   frame_period,
    input  logic [msp_pkg::MIN_W-1:0]     min_pulse,
    input  logic [msp_pkg::STEP_W-1:0]    step_ticks,
    output msp_pkg::timing_t              timing
);

    typedef enum logic [1:0] {PH_MIN, PH_STEP, PH_IDLE} phase_t;

    localparam logic [msp_pkg::STEP_IDX_W-1:0] LAST_STEP = msp_pkg::STEP_IDX_W'(STEPS);

    logic [msp_pkg::FRAME_W-1:0]    frame_tick_reg, frame_tick_next, ft_inc;
    logic [msp_pkg::MIN_W-1:0]      step_tick_reg, step_tick_next, st_inc;
    logic [msp_pkg::STEP_IDX_W-1:0] step_idx_reg, step_idx_next, idx_inc;
    phase_t                         phase_reg, phase_next;

    always_comb begin
        ft_inc          = frame_tick_reg + 24'd1;
        st_inc          = step_tick_reg + 16'd1;
        idx_inc         = step_idx_reg + 9'd1;
        frame_tick_next = frame_tick_reg;
        step_tick_next  = step_tick_reg;
        step_idx_next   = step_idx_reg;
        phase_next      = phase_reg;
        timing          = '0;
        if (tick_en) begin
            frame_tick_next = (ft_inc >= frame_period) ? '0 : ft_inc;
            if (frame_tick_reg == '0) begin
                // frame start: restart pulse timing, skip minimum pulse if zero
                timing.start   = 1'b1;
                step_tick_next = '0;
                step_idx_next  = '0;
                phase_next     = (min_pulse == '0) ? PH_STEP : PH_MIN;
            end else begin
                unique case (phase_reg)
                    PH_MIN: begin
                        if (st_inc >= min_pulse) begin
                            phase_next     = PH_STEP;
                            step_tick_next = '0;
                        end else begin
                            step_tick_next = st_inc;
                        end
                    end
                    PH_STEP: begin
                        if (st_inc >= {6'd0, step_ticks}) begin
                            step_tick_next   = '0;
                            step_idx_next    = idx_inc;
                            timing.step_done = 1'b1;
                            if (idx_inc >= LAST_STEP) begin
                                timing.all_low = 1'b1;
                                phase_next     = PH_IDLE;
                            end
                        end else begin
                            step_tick_next = st_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        timing.step_index = step_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_tick_reg <= '0;
            step_tick_reg  <= '0;
            step_idx_reg   <= '0;
            phase_reg      <= PH_MIN;
        end else begin
            frame_tick_reg <= frame_tick_next;
            step_tick_reg  <= step_tick_next;
            step_idx_reg   <= step_idx_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

// ===== hdl/msp_channel_bank.sv =====
// ----------------------------------------------------------------------------
// Servo PWM channel bank
// Pending and active position stores and the per-channel output levels.
// ----------------------------------------------------------------------------
module msp_channel_bank #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        write_en,
    input  logic [msp_pkg::CHAN_W-1:0]  wr_channel,
    input  logic [msp_pkg::POS_W-1:0]   wr_position,
    input  logic                        tick_en,
    input  msp_pkg::timing_t            timing,
    output logic [CHANNELS-1:0]         levels_next
);

    logic [msp_pkg::POS_W-1:0] pending_reg [CHANNELS];
    logic [msp_pkg::POS_W-1:0] active_reg  [CHANNELS];
    logic [CHANNELS-1:0]       levels_reg;
    logic [CHANNELS-1:0]       wr_hit;

    always_comb begin
        for (int n = 0; n < CHANNELS; n++) begin
            wr_hit[n] = write_en && (7'(wr_channel) == 7'(n));
        end
    end

    // levels drop as each channel's step passes; frame start raises all
    always_comb begin
        levels_next = levels_reg;
        if (tick_en && timing.start) begin
            levels_next = '1;
        end else if (tick_en && timing.step_done) begin
            for (int n = 0; n < CHANNELS; n++) begin
                if ({1'b0, active_reg[n]} < timing.step_index) begin
                    levels_next[n] = 1'b0;
                end
            end
            if (timing.all_low) begin
                levels_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= '1;
            for (int n = 0; n < CHANNELS; n++) begin
                pending_reg[n] <= msp_pkg::POS_RST;
                active_reg[n]  <= msp_pkg::POS_RST;
            end
        end else begin
            levels_reg <= levels_next;
            for (int n = 0; n < CHANNELS; n++) begin
                if (wr_hit[n]) begin
                    pending_reg[n] <= wr_position;
                end
                if (tick_en && timing.start) begin
                    active_reg[n] <= pending_reg[n];
                end
            end
        end
    end

endmodule

// ===== hdl/multichannel_servo_pwm_core.sv =====
// ----------------------------------------------------------------------------
// Multichannel servo PWM core
// Generates RC servo pulses on CHANNELS outputs from 8-bit positions.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per timer tick (tuser = 0) or a position write
//   (tuser = 1, tdata carries channel and position). Every request yields
//   exactly one result on the m_ channel: the pin levels after that request
//   and, in tuser, a flag that the tick began a new frame.
//   cfg_ channel: register writes (0 frame period, 1 minimum pulse,
//   2 step ticks), always ready; write only while the core is idle.
// Pipeline and throughput:
//   A request is registered on entry, then processed by the frame timer and
//   channel bank into the result register, which raises m_tvalid. One request
//   per cycle is sustained while the sink keeps m_tready high.
// Reset (aresetn low, synchronous): registers return to their defaults,
//   all positions to 128, all pins high, frame counter to frame start.
// Stall: when m_tready is low the result register holds; the input register
//   still takes one more request, then s_tready drops until the sink drains.
// ----------------------------------------------------------------------------
`include "multichannel_servo_pwm_core_defines.svh"

module multichannel_servo_pwm_core #(
    parameter int CHANNELS = msp_pkg::CHANNELS_DEF,
    parameter int STEPS    = msp_pkg::STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [4:0] channel, [12:5] position
    input  logic [0:0]                      s_tuser,   // [0] kind
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((CHANNELS+7)/8)*8-1:0]   m_tdata,   // [CHANNELS-1:0] pin_levels
    output logic [0:0]                      m_tuser,   // [0] frame_start
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [msp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int TDATA_W = ((CHANNELS + 7) / 8) * 8;

    // configuration registers
    logic [msp_pkg::FRAME_W-1:0] frame_period_reg;
    logic [msp_pkg::MIN_W-1:0]   min_pulse_reg;
    logic [msp_pkg::STEP_W-1:0]  step_ticks_reg;

    // input register
    logic                        in_valid_reg;
    logic                        in_kind_reg;
    logic [msp_pkg::CHAN_W-1:0]  in_channel_reg;
    logic [msp_pkg::POS_W-1:0]   in_position_reg;

    // result register
    logic                        out_valid_reg;
    logic [CHANNELS-1:0]         pin_reg;
    logic                        start_reg;

    logic                        advance;
    logic                        tick_en;
    logic                        write_en;
    msp_pkg::timing_t            timing;
    logic [CHANNELS-1:0]         levels_next;

    // the processing stage moves whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign tick_en   = advance && (in_kind_reg == msp_pkg::KIND_TICK);
    assign write_en  = advance && (in_kind_reg == msp_pkg::KIND_WRITE);
    assign cfg_ready = 1'b1;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = TDATA_W'(pin_reg);
    assign m_tuser   = start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_period_reg <= msp_pkg::FRAME_PERIOD_RST;
            min_pulse_reg    <= msp_pkg::MIN_PULSE_RST;
            step_ticks_reg   <= msp_pkg::STEP_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                msp_pkg::CFG_FRAME_PERIOD: frame_period_reg <= cfg_data;
                msp_pkg::CFG_MIN_PULSE:    min_pulse_reg    <= cfg_data[15:0];
                msp_pkg::CFG_STEP_TICKS:   step_ticks_reg   <= cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg     <= s_tuser[0];
            in_channel_reg  <= s_tdata[4:0];
            in_position_reg <= s_tdata[12:5];
        end
        if (advance) begin
            pin_reg   <= levels_next;
            start_reg <= tick_en && timing.start;
        end
    end

    msp_frame_timer #(
        .STEPS(STEPS)
    ) u_timer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_en      (tick_en),
        .frame_period (frame_period_reg),
        .min_pulse    (min_pulse_reg),
        .step_ticks   (step_ticks_reg),
        .timing       (timing)
    );

    msp_channel_bank #(
        .CHANNELS(CHANNELS)
    ) u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .write_en    (write_en),
        .wr_channel  (in_channel_reg),
        .wr_position (in_position_reg),
        .tick_en     (tick_en),
        .timing      (timing),
        .levels_next (levels_next)
    );

    // a frame-start result always shows every pin high
    `MSP_ASSERT_NOW(a_start_all_high, aclk, aresetn, out_valid_reg && start_reg, &pin_reg)

    // the last step drives every pin low in the result that follows
    `MSP_ASSERT_NEXT(a_last_step_low, aclk, aresetn, tick_en && timing.all_low, pin_reg == '0)

    // input stalls only when both stages are full and the sink holds off
    `MSP_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_tready,
                    in_valid_reg && out_valid_reg && !m_tready)

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// Servo PWM core testbench
// Streams tick and position-write requests into the multichannel servo PWM
// core under random source bursts and sink stalls, predicts the pin levels and
// frame-start flag of every request, and checks each result in order. Runs
// through several frame/pulse/step register settings, zero values and
// extremes among them.
// ============================================================================
module testbench;

    localparam int CHANNELS         = msp_pkg::CHANNELS_DEF;
    localparam int STEPS            = msp_pkg::STEPS_DEF;
    localparam int PINS_W           = ((CHANNELS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 6;     // margin kept after the last result is checked
    localparam int LONG_HOLD_AT     = 150;   // results seen before the long sink stall
    localparam int LONG_HOLD_CYCLES = 80;

    // one input request: tick or position write
    typedef struct packed {
        logic                       kind;
        logic [msp_pkg::CHAN_W-1:0] channel;
        logic [msp_pkg::POS_W-1:0]  position;
    } servo_req_t;

    // one result: pin levels after the request, frame-start flag
    typedef struct packed {
        logic [CHANNELS-1:0] pins;
        logic                frame_start;
    } pin_state_t;

    typedef enum logic [1:0] {
        PHASE_MIN_PULSE,
        PHASE_STEPPING,
        PHASE_ALL_LOW
    } pulse_phase_e;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------------
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;
    logic [0:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [PINS_W-1:0]              m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [msp_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [msp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    always #6 aclk = ~aclk;

    multichannel_servo_pwm_core #(
        .CHANNELS (CHANNELS),
        .STEPS    (STEPS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Servo timing predictor: registers and state
    // ------------------------------------------------------------------------
    logic [msp_pkg::FRAME_W-1:0]    cfg_frame;
    logic [msp_pkg::MIN_W-1:0]      cfg_min;
    logic [msp_pkg::STEP_W-1:0]     cfg_step;

    logic [msp_pkg::FRAME_W-1:0]    frame_count;    // ticks into the current frame
    logic [msp_pkg::MIN_W-1:0]      pulse_count;    // ticks into min pulse or current step
    logic [msp_pkg::STEP_IDX_W-1:0] steps_passed;
    pulse_phase_e                   pulse_phase;
    logic [msp_pkg::POS_W-1:0]      active_pos  [CHANNELS];
    logic [msp_pkg::POS_W-1:0]      pending_pos [CHANNELS];
    logic [CHANNELS-1:0]            pins_now;

    servo_req_t servo_req_q[$];            // requests waiting for the driver
    pin_state_t expected_pins_q[$];        // predicted results, oldest first

    int requests_queued   = 0;
    int requests_accepted = 0;
    int results_checked   = 0;
    int ticks_applied     = 0;
    int frames_started    = 0;
    int settings_used     = 0;
    int error_count       = 0;
    int cycle_count       = 0;

    function automatic void reset_servo_state();
        cfg_frame    = msp_pkg::FRAME_PERIOD_RST;
        cfg_min      = msp_pkg::MIN_PULSE_RST;
        cfg_step     = msp_pkg::STEP_TICKS_RST;
        frame_count  = '0;
        pulse_count  = '0;
        steps_passed = '0;
        pulse_phase  = PHASE_MIN_PULSE;
        for (int n = 0; n < CHANNELS; n++) begin
            active_pos[n]  = msp_pkg::POS_RST;
            pending_pos[n] = msp_pkg::POS_RST;
        end
        pins_now = '1;
    endfunction

    // Pulse timer for one tick: min pulse first, then STEPS position steps.
    // A zero step length behaves as one tick since the count is bumped first.
    function automatic void step_pulse_timer();
        if (pulse_phase == PHASE_MIN_PULSE) begin
            if (pulse_count >= cfg_min) begin
                pulse_phase = PHASE_STEPPING;
                pulse_count = '0;
            end
        end else if (pulse_phase == PHASE_STEPPING) begin
            pulse_count = pulse_count + 16'd1;
            if (pulse_count >= 16'(cfg_step)) begin
                pulse_count  = '0;
                steps_passed = steps_passed + 1'b1;
                // channel with position v drops once v+1 steps have passed
                for (int n = 0; n < CHANNELS; n++)
                    if (msp_pkg::STEP_IDX_W'(active_pos[n]) < steps_passed)
                        pins_now[n] = 1'b0;
                if (steps_passed >= STEPS) begin
                    pins_now    = '0;
                    pulse_phase = PHASE_ALL_LOW;
                end
            end
        end
    endfunction

    // Apply one accepted request to the predictor, return the expected result.
    function automatic pin_state_t apply_servo_request(servo_req_t req);
        pin_state_t res;
        res.frame_start = 1'b0;
        if (req.kind == msp_pkg::KIND_WRITE) begin
            // out-of-range channels are dropped; writes land in pending only
            if (req.channel < CHANNELS)
                pending_pos[req.channel] = req.position;
        end else begin
            ticks_applied++;
            if (frame_count == '0) begin
                // frame start: latch positions, raise every pin, restart timing
                res.frame_start = 1'b1;
                frames_started++;
                active_pos   = pending_pos;
                pins_now     = '1;
                pulse_count  = '0;
                steps_passed = '0;
                pulse_phase  = PHASE_MIN_PULSE;
            end else if (pulse_phase == PHASE_MIN_PULSE) begin
                pulse_count = pulse_count + 16'd1;
            end
            step_pulse_timer();
            // period 0 wraps every tick, same as period 1
            frame_count = frame_count + 1'b1;
            if (frame_count >= cfg_frame)
                frame_count = '0;
        end
        res.pins = pins_now;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_request(servo_req_t req);
        servo_req_q.push_back(req);
        requests_queued++;
    endfunction

    // Mostly ticks; writes mostly hit valid channels, positions often kept
    // at or below pos_max so that pins drop early in short frames.
    function automatic servo_req_t random_request(int write_pct, int pos_max);
        servo_req_t req;
        req.channel  = msp_pkg::CHAN_W'($urandom_range(0, 31));
        req.position = msp_pkg::POS_W'($urandom);
        if ($urandom_range(0, 99) < write_pct) begin
            req.kind = msp_pkg::KIND_WRITE;
            if ($urandom_range(0, 4) != 0)
                req.channel = msp_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1));
            if ($urandom_range(0, 3) != 0)
                req.position = msp_pkg::POS_W'($urandom_range(0, pos_max));
        end else begin
            req.kind = msp_pkg::KIND_TICK;
        end
        return req;
    endfunction

    // Source stops until every queued request is through and answered.
    task automatic wait_drained();
        while (requests_accepted != requests_queued || expected_pins_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [msp_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [msp_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (addr)
            msp_pkg::CFG_FRAME_PERIOD: cfg_frame = value[msp_pkg::FRAME_W-1:0];
            msp_pkg::CFG_MIN_PULSE:    cfg_min   = value[msp_pkg::MIN_W-1:0];
            msp_pkg::CFG_STEP_TICKS:   cfg_step  = value[msp_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input logic [msp_pkg::FRAME_W-1:0] frame,
                                    input logic [msp_pkg::MIN_W-1:0]   min_pulse,
                                    input logic [msp_pkg::STEP_W-1:0]  step);
        wait_drained();
        write_register(msp_pkg::CFG_FRAME_PERIOD, msp_pkg::CFG_DATA_W'(frame));
        write_register(msp_pkg::CFG_MIN_PULSE,    msp_pkg::CFG_DATA_W'(min_pulse));
        write_register(msp_pkg::CFG_STEP_TICKS,   msp_pkg::CFG_DATA_W'(step));
        settings_used++;
    endtask

    task automatic run_segment(input logic [msp_pkg::FRAME_W-1:0] frame,
                               input logic [msp_pkg::MIN_W-1:0]   min_pulse,
                               input logic [msp_pkg::STEP_W-1:0]  step,
                               input int count, input int write_pct, input int pos_max);
        program_settings(frame, min_pulse, step);
        repeat (count) queue_request(random_request(write_pct, pos_max));
    endtask

    // ------------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps in between.
    // A new request is only put up once the previous one was taken.
    // ------------------------------------------------------------------------
    servo_req_t offered;

    always @(posedge aclk) begin : request_driver
        servo_req_t next_req;
        int         burst_left;
        int         gap_left;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pins_q.push_back(apply_servo_request(offered));
                requests_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (servo_req_q.size() != 0) begin
                    next_req = servo_req_q.pop_front();
                    offered  <= next_req;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, next_req.position, next_req.channel};
                    s_tuser  <= next_req.kind;
                    // end of burst: pick the next length and maybe a gap
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and sink. Ready pattern follows sink_cycle[7:6]; one long
    // hold-off lets the core fill up and push back on the source.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : pin_monitor
        pin_state_t want;
        int         sink_cycle;
        int         hold_left;
        bit         long_hold_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (expected_pins_q.size() == 0) begin
                    error_count++;
                    $display("%0t: result with nothing pending: pins %h frame_start %b",
                             $time, m_tdata[CHANNELS-1:0], m_tuser[0]);
                end else begin
                    want = expected_pins_q.pop_front();
                    if (m_tdata[CHANNELS-1:0] !== want.pins) begin
                        error_count++;
                        $display("%0t: pin_levels mismatch: expected %h, got %h",
                                 $time, want.pins, m_tdata[CHANNELS-1:0]);
                    end
                    if (m_tuser[0] !== want.frame_start) begin
                        error_count++;
                        $display("%0t: frame_start mismatch: expected %b, got %b",
                                 $time, want.frame_start, m_tuser[0]);
                    end
                end
            end
            sink_cycle++;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && results_checked >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES - 1;
                m_tready       <= 1'b0;
            end else begin
                case (sink_cycle[7:6])
                    2'd0:    m_tready <= 1'b1;                           // no stalls
                    2'd1:    m_tready <= $urandom_range(0, 1) != 0;      // coin flip
                    2'd2:    m_tready <= sink_cycle[1:0] != 2'b11;       // one in four
                    default: m_tready <= $urandom_range(0, 4) == 0;      // mostly stalled
                endcase
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_servo_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: first tick starts a frame, tick fields are don't-care,
        // out-of-range channel writes are dropped
        queue_request({msp_pkg::KIND_TICK,  5'd31, 8'hFF});
        queue_request({msp_pkg::KIND_WRITE, 5'd0,  8'd0});
        queue_request({msp_pkg::KIND_WRITE, 5'd23, 8'd255});
        queue_request({msp_pkg::KIND_WRITE, 5'd24, 8'h55});
        queue_request({msp_pkg::KIND_WRITE, 5'd31, 8'hAA});
        queue_request({msp_pkg::KIND_TICK,  5'd0,  8'd0});

        // zero period, zero min pulse, zero step: every tick is a frame start
        program_settings('0, '0, '0);
        queue_request({msp_pkg::KIND_TICK,  5'd10, 8'h5A});
        queue_request({msp_pkg::KIND_WRITE, 5'd1,  8'd1});
        queue_request({msp_pkg::KIND_TICK,  5'd0,  8'd0});

        // short frame, stepping from the start tick, one tick per step:
        // low positions drop one after another, tick 13 restarts the frame
        program_settings(24'd12, '0, '0);
        queue_request({msp_pkg::KIND_WRITE, 5'd2,  8'd2});
        queue_request({msp_pkg::KIND_WRITE, 5'd10, 8'h55});
        queue_request({msp_pkg::KIND_WRITE, 5'd21, 8'hAA});
        repeat (14) queue_request({msp_pkg::KIND_TICK, 5'd0, 8'd0});

        // random segments: frame, min pulse, step, requests, write %, pos range
        run_segment(24'd270,      16'd1,     10'd1,    290, 5,  255);  // full sweep
        run_segment(24'd50,       16'd3,     10'd2,     40, 25, 30);   // cut short
        run_segment(24'd1,        16'd0,     10'd1,     20, 30, 255);  // every tick
        run_segment(24'd16777215, 16'd65535, 10'd1023,  20, 30, 255);  // extremes
        run_segment(24'd9,        16'd1,     10'd1,     24, 40, 10);

        wait_drained();

        $display("summary: %0d requests (%0d ticks, %0d frame starts), %0d results checked",
                 requests_accepted, ticks_applied, frames_started, results_checked);
        $display("summary: %0d register settings plus reset values, %0d mismatches",
                 settings_used, error_count);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
